// File: sv/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// request queue between front and back; depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	localparam int MAX_BYTES = 3;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_PCT,
		ESC_DIG
	} esc_t;

	// one decoded request: up to three bytes, count in 1..3
	typedef struct packed {
		logic [1:0]                     cnt;
		logic [MAX_BYTES-1:0][7:0]      bytes;
		logic                           last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		if (c <= 8'h39) begin
			hex_nib = c[3:0];
		end else begin
			hex_nib = c[3:0] + 4'd9;
		end
	endfunction

endpackage

// File: sv/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Streaming URL percent decoder. Encoded characters enter one per cycle on the
// in_* channel, with in_last on the final character of a string; decoded bytes
// leave on the out_* channel, out_last on the final one. A plus becomes a
// space, a percent sign with two hex digits becomes the byte they spell (zero
// included), and a broken escape is passed through literally. Each accepted
// character makes between zero and three output bytes. The input side takes
// one character per cycle while the queue has room; the output side delivers
// one byte per cycle while out_stall is low, so a character that expands to
// two or three bytes, or a stalled output, holds the input back once the
// two-request queue between the front and the back fills.
module url_percent_decoder import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    head;
	q_status_t q_status;

	// hold the input only while the request queue is full
	assign in_stall = q_status.full;

	// classify each character and form its output request
	upd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.push       (push),
		.push_entry (push_entry)
	);

	// buffer requests so front and back stall independently
	upd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// advance through request bytes, one per cycle while the output is not stalled, into the output register
	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

// File: sv/upd_front.sv
// Front part: accept characters, track the escape state, build output requests.
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output entry_t     push_entry
);

	esc_t       st_q, st_d;
	logic [7:0] held_q, held_d;
	logic       accept;
	logic       hex;

	assign accept = in_valid && !in_stall;
	assign hex    = is_hex(in_byte);

	// next state
	always_comb begin
		st_d   = st_q;
		held_d = held_q;
		if (accept) begin
			case (st_q)
				ESC_PCT: begin
					if (hex) begin
						st_d   = ESC_DIG;
						held_d = in_byte;
					end else begin
						st_d = (in_byte == CH_PERCENT) ? ESC_PCT : ESC_IDLE;
					end
				end
				ESC_DIG: begin
					if (hex) begin
						st_d = ESC_IDLE;
					end else begin
						st_d = (in_byte == CH_PERCENT) ? ESC_PCT : ESC_IDLE;
					end
				end
				default: begin
					st_d = (in_byte == CH_PERCENT) ? ESC_PCT : ESC_IDLE;
				end
			endcase
			if (in_last) begin
				st_d   = ESC_IDLE;
				held_d = 8'h00;
			end
		end
	end

	// outputs: bytes carried over from the escape, then the fresh byte
	always_comb begin
		logic [1:0] n;
		logic       fresh;
		n          = 2'd0;
		fresh      = 1'b1;
		push_entry = '0;
		case (st_q)
			ESC_PCT: begin
				if (hex) begin
					fresh = 1'b0;
					if (in_last) begin
						push_entry.bytes[0] = CH_PERCENT;
						push_entry.bytes[1] = in_byte;
						n = 2'd2;
					end
				end else begin
					push_entry.bytes[0] = CH_PERCENT;
					n = 2'd1;
				end
			end
			ESC_DIG: begin
				if (hex) begin
					fresh = 1'b0;
					push_entry.bytes[0] = {hex_nib(held_q), hex_nib(in_byte)};
					n = 2'd1;
				end else begin
					push_entry.bytes[0] = CH_PERCENT;
					push_entry.bytes[1] = held_q;
					n = 2'd2;
				end
			end
			default: begin
				n = 2'd0;
			end
		endcase
		if (fresh) begin
			if (in_byte == CH_PERCENT) begin
				if (in_last) begin
					push_entry.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
				end
			end else if (in_byte == CH_PLUS) begin
				push_entry.bytes[n] = CH_SPACE;
				n = n + 2'd1;
			end else begin
				push_entry.bytes[n] = in_byte;
				n = n + 2'd1;
			end
		end
		push_entry.cnt  = n;
		push_entry.last = in_last;
		push            = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ESC_IDLE;
			held_q <= 8'h00;
		end else begin
			st_q   <= st_d;
			held_q <= held_d;
		end
	end

endmodule

// File: sv/upd_queue.sv
// Short request queue that decouples the front from the back.
module upd_queue import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t status
);

	entry_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign head            = mem_q[rd_ptr_q];
	assign status.full     = (count_q == QCW'(QDEPTH));
	assign status.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/upd_back.sv
// Back part: walk the bytes of each queued request into the output register.
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  q_status_t  status,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [1:0] sel_q;
	logic       load;
	logic       at_end;
	logic [7:0] cur_byte;

	assign load   = status.nonempty && (!out_valid || !out_stall);
	assign at_end = (sel_q == head.cnt - 2'd1);
	assign pop    = load && at_end;

	always_comb begin
		case (sel_q)
			2'd0:    cur_byte = head.bytes[0];
			2'd1:    cur_byte = head.bytes[1];
			default: cur_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sel_q     <= 2'd0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				sel_q     <= at_end ? 2'd0 : sel_q + 2'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= cur_byte;
			out_last <= head.last && at_end;
		end
	end

endmodule

// File: sv/upd_checker.sv
// Port-level checker for the URL percent decoder, bound to the top level.
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled result stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output changed");

	// no output is shown while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// an empty output register means the queue has room
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output idle");

	// the input side never stalls in the cycle right after reset
	a_first_free: assert property (@(posedge clk) $rose(arst_n) |-> !in_stall)
		else $error("input stalled right after reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 100ps

module tb_top;
	import upd_pkg::*;

	// one decoded byte as it should leave the block
	typedef struct {
		logic [7:0] b;
		logic       l;
	} dec_byte_t;

	// Tracks the escape state of the string being decoded and keeps the
	// decoded bytes still owed by the block, oldest first.
	class decode_scoreboard;
		esc_t       esc;
		logic [7:0] held;
		dec_byte_t  owed_bytes[$];
		int         failures;

		function new();
			esc      = ESC_IDLE;
			held     = 8'h00;
			failures = 0;
		endfunction

		static function int digit_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
			return -1;
		endfunction

		// decode one accepted request and queue the bytes it must produce
		function void note_request(logic [7:0] c, logic l);
			dec_byte_t step_q[$];
			int        v;
			int        h;
			bit        fresh;
			v     = digit_value(c);
			fresh = 0;
			case (esc)
				ESC_PCT: begin
					if (v >= 0) begin
						held = c;
						esc  = ESC_DIG;
						if (l) begin
							step_q.push_back('{CH_PERCENT, 1'b0});
							step_q.push_back('{c, 1'b0});
						end
					end else begin
						step_q.push_back('{CH_PERCENT, 1'b0});
						esc   = ESC_IDLE;
						fresh = 1;
					end
				end
				ESC_DIG: begin
					if (v >= 0) begin
						h = digit_value(held);
						if (h < 0) h = 0;
						step_q.push_back('{8'(h * 16 + v), 1'b0});
						esc = ESC_IDLE;
					end else begin
						step_q.push_back('{CH_PERCENT, 1'b0});
						step_q.push_back('{held, 1'b0});
						esc   = ESC_IDLE;
						fresh = 1;
					end
				end
				default: begin
					esc   = ESC_IDLE;
					fresh = 1;
				end
			endcase
			if (fresh) begin
				if (c == CH_PERCENT) begin
					esc = ESC_PCT;
					if (l) step_q.push_back('{CH_PERCENT, 1'b0});
				end else if (c == CH_PLUS) begin
					step_q.push_back('{CH_SPACE, 1'b0});
				end else begin
					step_q.push_back('{c, 1'b0});
				end
			end
			if (l) begin
				if (step_q.size() > 0) step_q[$].l = 1'b1;
				esc  = ESC_IDLE;
				held = 8'h00;
			end
			foreach (step_q[k]) owed_bytes.push_back(step_q[k]);
		endfunction

		function void check_result(logic [7:0] b, logic l);
			dec_byte_t want;
			if (owed_bytes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected output: byte %h last %b", b, l);
				return;
			end
			want = owed_bytes.pop_front();
			if (b !== want.b || l !== want.l) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected byte %h last %b, got byte %h last %b",
						want.b, want.l, b, l);
			end
		endfunction

		function bit busy();
			return owed_bytes.size() != 0;
		endfunction

		// anything still owed at the end is a missing output
		function void close_out();
			if (owed_bytes.size() != 0) begin
				failures += owed_bytes.size();
				$display("%0d output bytes never arrived, first expected %h last %b",
					owed_bytes.size(), owed_bytes[0].b, owed_bytes[0].l);
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	decode_scoreboard sb = new();

	// suppress random idling on both sides while set
	bit calm = 0;
	// count of characters handed to the block so far
	int sent = 0;

	url_percent_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	always #5 clk = ~clk;

	// Output side: check every accepted byte against the oldest owed one,
	// then pick the stall for the next cycle. Values read here are the ones
	// present just before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_byte, out_last);
		out_stall <= !calm && ($urandom_range(99) < 14);
	end

	// Hand one character to the block: idle at random first, then hold the
	// request until it is taken, and note it with the scoreboard.
	task automatic send_char(logic [7:0] c, logic l);
		if (!calm) begin
			while ($urandom_range(99) < 14) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		in_last  <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(c, l);
		sent++;
	endtask

	// Drop valid and hold off until every owed byte has come out.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.busy()) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_hex();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (decode_scoreboard::digit_value(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (c == CH_PERCENT);
		return c;
	endfunction

	// Build one string, mostly well-formed pieces with random content plus
	// broken and truncated escapes; now and then pure noise.
	task automatic send_random_string();
		logic [7:0] text[$];
		int         pieces;
		int         kind;
		pieces = $urandom_range(1, 6);
		if ($urandom_range(99) < 10) begin
			repeat (pieces * 2) text.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat (pieces) begin
				kind = $urandom_range(99);
				if (kind < 40) begin
					text.push_back(pick_plain());
				end else if (kind < 52) begin
					text.push_back(CH_PLUS);
				end else if (kind < 80) begin
					text.push_back(CH_PERCENT);
					text.push_back(pick_hex());
					text.push_back(pick_hex());
				end else if (kind < 85) begin
					text.push_back(CH_PERCENT);
				end else if (kind < 90) begin
					text.push_back(CH_PERCENT);
					text.push_back(pick_hex());
				end else if (kind < 95) begin
					text.push_back(CH_PERCENT);
					text.push_back(pick_non_hex());
				end else begin
					text.push_back(CH_PERCENT);
					text.push_back(pick_hex());
					text.push_back(pick_non_hex());
				end
			end
		end
		for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
	endtask

	initial begin
		// Directed strings: plain and hex-letter characters, plus, zero and
		// all-ones bytes; valid escapes in both cases spelling 0x41, zero and
		// 0xFF; percent at end of string; percent and digit at end of string;
		// an escape broken by a new percent; a held digit broken by a percent
		// and by a non-hex letter; an escape broken by a plus.
		logic [7:0] dir_b[26] = '{
			8'h61, CH_PLUS, 8'h00, 8'hFF,
			8'h01,
			CH_PERCENT, 8'h34, 8'h31,
			CH_PERCENT, 8'h30, 8'h30,
			CH_PERCENT, 8'h66, 8'h46, CH_PERCENT,
			CH_PERCENT, 8'h61,
			CH_PERCENT, CH_PERCENT, 8'h32, 8'h62,
			CH_PERCENT, 8'h37, CH_PERCENT, 8'h34, 8'h67
		};
		bit dir_l[26] = '{
			0, 0, 0, 0,
			1,
			0, 0, 1,
			0, 0, 0,
			0, 0, 0, 1,
			0, 1,
			0, 0, 0, 1,
			0, 0, 0, 0, 1
		};
		bit pressed;
		pressed = 0;
		// drive reset low at time zero so the block sees a falling edge
		arst_n <= 1'b0;

		// hold reset low, then release it on an edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_b[k]) send_char(dir_b[k], dir_l[k]);
		send_char(CH_PERCENT, 1'b0);
		send_char(CH_PLUS, 1'b1);
		drain_outputs();

		// random strings; a calm stretch in the middle, one full drain later
		while (sent < 230) begin
			calm = (sent >= 90 && sent < 150);
			if (!pressed && sent >= 170) begin
				drain_outputs();
				pressed = 1;
			end
			send_random_string();
		end
		calm = 0;

		// wait out every owed byte, then wait on for strays
		drain_outputs();
		repeat (10) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0) begin
			$display("** url_percent_decoder: PASSED **");
		end else begin
			$display("** url_percent_decoder: FAILED **");
		end
		$finish;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2000000;
		$display("timeout waiting on the decoder");
		$display("** url_percent_decoder: FAILED **");
		$finish;
	end

endmodule
